FILE: design/sud_pkg.sv
// ----------------------------------------------------------------------------
// Divider package
// Types and constants shared by the divider sequencer, datapath and top level.
// ----------------------------------------------------------------------------
package sud_pkg;

	localparam logic ACTION_UNSIGNED = 1'b0;
	localparam logic ACTION_SIGNED   = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_t;

endpackage

FILE: design/sud_req_if.sv
// ----------------------------------------------------------------------------
// Divider request channel
// Valid/ready channel that carries one division transaction.
// ----------------------------------------------------------------------------
interface sud_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [DATA_WIDTH-1:0] dividend;
	logic [DATA_WIDTH-1:0] divisor;

	modport source (output valid, output action, output dividend, output divisor,
		input ready);
	modport sink (input valid, input action, input dividend, input divisor,
		output ready);
endinterface

FILE: design/sud_rsp_if.sv
// ----------------------------------------------------------------------------
// Divider response channel
// Valid/ready channel that carries the quotient and remainder of a transaction.
// ----------------------------------------------------------------------------
interface sud_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] quotient;
	logic [DATA_WIDTH-1:0] remainder;

	modport source (output valid, output quotient, output remainder, input ready);
	modport sink (input valid, input quotient, input remainder, output ready);
endinterface

FILE: design/sud_seq.sv
// ----------------------------------------------------------------------------
// Divider sequencer
// Steps the shared subtract unit once per quotient bit and hands the result
// to the output register when it is free.
// ----------------------------------------------------------------------------
module sud_seq #(
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_full,
	input  logic           out_ready,
	output sud_pkg::ctrl_t ctrl
);
	import sud_pkg::*;

	localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		ctrl.load   = in_ready && in_valid;
		ctrl.step   = (state_q == ST_RUN);
		ctrl.finish = (state_q == ST_DONE) && (!out_full || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.load) begin
						state_q <= ST_RUN;
						count_q <= CW'(DATA_WIDTH - 1);
					end
				end
				ST_RUN: begin
					if (count_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_DONE: begin
					if (ctrl.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/sud_datapath.sv
// ----------------------------------------------------------------------------
// Divider datapath
// Operand magnitudes, the shared restoring subtract step and the sign fix-up.
// ----------------------------------------------------------------------------
module sud_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  sud_pkg::ctrl_t        ctrl,
	input  logic                  action,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);
	import sud_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] ONE = W'(1);

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic         rneg_q;
	logic         qneg_q;
	logic         zero_q;

	logic         a_neg;
	logic         b_neg;
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W-1:0] shifted;
	logic [W:0]   diff;

	always_comb begin
		a_neg   = (action == ACTION_SIGNED) && dividend[W-1];
		b_neg   = (action == ACTION_SIGNED) && divisor[W-1];
		a_mag   = a_neg ? (~dividend + ONE) : dividend;
		b_mag   = b_neg ? (~divisor + ONE) : divisor;
		shifted = {rem_q[W-2:0], quo_q[W-1]};
		diff    = {rem_q[W-1], shifted} - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q  <= '0;
			quo_q  <= a_mag;
			den_q  <= b_mag;
			rneg_q <= a_neg;
			qneg_q <= a_neg ^ b_neg;
			zero_q <= (divisor == '0);
		end else if (ctrl.step) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			quotient  = '0;
			remainder = '0;
		end else begin
			quotient  = qneg_q ? (~quo_q + ONE) : quo_q;
			remainder = rneg_q ? (~rem_q + ONE) : rem_q;
		end
	end

endmodule

FILE: design/signed_unsigned_int_divider.sv
// ----------------------------------------------------------------------------
// Signed and unsigned integer divider
// Radix-2 restoring divider for unsigned or two's complement operands.
// ----------------------------------------------------------------------------
// A transaction on the request channel carries the mode, dividend and divisor.
// The block answers each one with a single transaction on the response channel
// that carries the quotient, truncated toward zero, and the remainder, which
// takes the dividend's sign in signed mode. A zero divisor gives zero results.
// One shared subtract unit retires one quotient bit per cycle. A transaction
// loads the operand magnitudes, runs one subtract step per quotient bit and
// writes the sign-fixed results into the output register. The request channel
// is ready only while the sequencer is idle, so a new request is not taken
// until the previous division has been handed to the output register. The
// result waits in the output register while the receiver stalls; the next
// request is still taken and divided, and its result is held in the datapath
// until the output register frees up. Reset empties the output register and
// returns the sequencer to idle.
// ----------------------------------------------------------------------------
module signed_unsigned_int_divider #(
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	sud_req_if.sink   req,
	sud_rsp_if.source rsp
);
	import sud_pkg::*;

	ctrl_t                 ctrl;
	logic [DATA_WIDTH-1:0] quotient;
	logic [DATA_WIDTH-1:0] remainder;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] quotient_q;
	logic [DATA_WIDTH-1:0] remainder_q;

	sud_seq #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_full (out_valid_q),
		.out_ready(rsp.ready),
		.ctrl     (ctrl)
	);

	sud_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.ctrl     (ctrl),
		.action   (req.action),
		.dividend (req.dividend),
		.divisor  (req.divisor),
		.quotient (quotient),
		.remainder(remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			quotient_q  <= quotient;
			remainder_q <= remainder;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.quotient  = quotient_q;
	assign rsp.remainder = remainder_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("Request accepted while a division was already in progress.");

	a_finish_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> !req.ready)
		else $error("Result handed over while the sequencer was idle.");

	a_finish_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> rsp.valid)
		else $error("Finished division did not reach the output register.");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(ctrl.finish))
		else $error("Response became valid without a finished division.");
`endif

endmodule

FILE: test/tb_signed_unsigned_int_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider testbench
// Sends directed and random divisions in both modes and checks every quotient
// and remainder against a bit-serial predictor, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_signed_unsigned_int_divider;
	import sud_pkg::*;

	localparam int          W          = 32;
	localparam int          IDLE_LIMIT = 2000;
	localparam int          TAIL       = 60;
	localparam logic [W-1:0] MOST_NEG  = 32'h8000_0000;
	localparam logic [W-1:0] MOST_POS  = 32'h7fff_ffff;
	localparam logic [W-1:0] ALL_ONES  = 32'hffff_ffff;

	typedef struct packed {
		logic [W-1:0] quotient;
		logic [W-1:0] remainder;
	} div_result_t;

	logic clk;
	logic arst_n;

	sud_req_if #(.DATA_WIDTH(W)) req_ch ();
	sud_rsp_if #(.DATA_WIDTH(W)) rsp_ch ();

	signed_unsigned_int_divider #(.DATA_WIDTH(W)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	div_result_t pending_results[$];
	int          mismatches;
	int          results_checked;
	int          divisions_sent;
	int          signed_sent;
	int          zero_divisor_sent;
	int          idle_cycles;
	bit          sender_burst;
	bit          receiver_burst;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic div_result_t predict_division(input logic act, input logic [W-1:0] num,
		input logic [W-1:0] den);
		logic [W-1:0] num_mag;
		logic [W-1:0] den_mag;
		logic [W-1:0] part;
		logic [W-1:0] quo;
		logic         carry;
		logic         neg_num;
		logic         neg_den;
		div_result_t  res;
		neg_num = (act == ACTION_SIGNED) && num[W-1];
		neg_den = (act == ACTION_SIGNED) && den[W-1];
		num_mag = neg_num ? -num : num;
		den_mag = neg_den ? -den : den;
		part = '0;
		quo = '0;
		if (den_mag == '0) begin
			res.quotient = '0;
			res.remainder = '0;
			return res;
		end
		for (int i = W - 1; i >= 0; i--) begin
			carry = part[W-1];
			part = {part[W-2:0], num_mag[i]};
			quo = {quo[W-2:0], 1'b0};
			if (carry || part >= den_mag) begin
				part = part - den_mag;
				quo[0] = 1'b1;
			end
		end
		res.quotient = (neg_num != neg_den) ? -quo : quo;
		res.remainder = neg_num ? -part : part;
		return res;
	endfunction

	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] val;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 6))
					0: val = '0;
					1: val = 32'd1;
					2: val = ALL_ONES;
					3: val = MOST_NEG;
					4: val = MOST_POS;
					5: val = MOST_NEG + 32'd1;
					default: val = 32'd2;
				endcase
			end
			1: val = $urandom_range(0, 15);
			2: val = $urandom >> $urandom_range(0, W - 1);
			3: val = -($urandom >> $urandom_range(0, W - 1));
			default: val = $urandom;
		endcase
		return val;
	endfunction

	task automatic send_division(input logic act, input logic [W-1:0] num,
		input logic [W-1:0] den);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.dividend <= num;
		req_ch.divisor  <= den;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_division(act, num, den));
		divisions_sent++;
		if (act == ACTION_SIGNED)
			signed_sent++;
		if (den == '0)
			zero_divisor_sent++;
	endtask

	task automatic release_request();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_cases();
		send_division(ACTION_UNSIGNED, 32'd0, 32'd0);
		send_division(ACTION_UNSIGNED, ALL_ONES, 32'd0);
		send_division(ACTION_UNSIGNED, ALL_ONES, 32'd1);
		send_division(ACTION_UNSIGNED, ALL_ONES, ALL_ONES);
		send_division(ACTION_UNSIGNED, ALL_ONES, MOST_NEG);
		send_division(ACTION_UNSIGNED, MOST_POS, MOST_NEG);
		send_division(ACTION_UNSIGNED, 32'hc000_0001, 32'hc000_0000);
		send_division(ACTION_UNSIGNED, 32'd7, 32'd3);
		send_division(ACTION_UNSIGNED, 32'd3, 32'd7);
		send_division(ACTION_UNSIGNED, 32'h1234_5678, 32'h0000_0010);
		send_division(ACTION_SIGNED, MOST_NEG, ALL_ONES);
		send_division(ACTION_SIGNED, MOST_NEG, 32'd1);
		send_division(ACTION_SIGNED, MOST_NEG, MOST_NEG);
		send_division(ACTION_SIGNED, MOST_NEG, 32'd0);
		send_division(ACTION_SIGNED, ALL_ONES, 32'd0);
		send_division(ACTION_SIGNED, -32'sd7, 32'd2);
		send_division(ACTION_SIGNED, 32'd7, -32'sd2);
		send_division(ACTION_SIGNED, -32'sd7, -32'sd2);
		send_division(ACTION_SIGNED, MOST_POS, MOST_NEG);
		send_division(ACTION_SIGNED, ALL_ONES, MOST_NEG);
		send_division(ACTION_SIGNED, MOST_POS, ALL_ONES);
		send_division(ACTION_SIGNED, MOST_NEG, 32'd3);
		send_division(ACTION_SIGNED, 32'd0, ALL_ONES);
		release_request();
	endtask

	task automatic test_random_divisions(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 0) begin
				sender_burst = ($urandom_range(0, 3) == 0);
				receiver_burst = ($urandom_range(0, 3) == 0);
			end
			send_division(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
		end
		sender_burst = 1'b0;
		receiver_burst = 1'b0;
		release_request();
	endtask

	task automatic test_back_to_back(input int count);
		sender_burst = 1'b1;
		receiver_burst = 1'b1;
		for (int n = 0; n < count; n++)
			send_division(1'($urandom_range(0, 1)), $urandom, pick_operand());
		sender_burst = 1'b0;
		receiver_burst = 1'b0;
		release_request();
	endtask

	task automatic test_drain_between_groups(input int groups);
		for (int g = 0; g < groups; g++) begin
			repeat ($urandom_range(1, 12))
				send_division(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
			release_request();
			wait_for_results();
		end
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int          stall;
			div_result_t want;
			stall = receiver_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			results_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending: quotient %h remainder %h",
						$realtime, rsp_ch.quotient, rsp_ch.remainder);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.quotient !== want.quotient || rsp_ch.remainder !== want.remainder) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch: quotient %h (want %h) remainder %h (want %h)",
							$realtime, rsp_ch.quotient, want.quotient,
							rsp_ch.remainder, want.remainder);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.action   = ACTION_UNSIGNED;
		req_ch.dividend = '0;
		req_ch.divisor  = '0;
		mismatches      = 0;
		results_checked = 0;
		divisions_sent  = 0;
		signed_sent     = 0;
		zero_divisor_sent = 0;
		sender_burst    = 1'b0;
		receiver_burst  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_divisions(1400);
		test_back_to_back(200);
		test_drain_between_groups(30);

		wait_for_results();
		repeat (TAIL) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("summary: %0d divisions sent, %0d signed and %0d by zero.",
			divisions_sent, signed_sent, zero_divisor_sent);
		$display("summary: %0d results checked, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
